FILE: sv/line_rasterizer_assert.svh
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Checked at every rising clock edge, switched off while reset is high
`define LR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included
`define LR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lr_pkg.sv
package lr_pkg;

   // Coordinate width of endpoints and pixels
   localparam int COORD_BITS = 16;
   // Error term: twice a magnitude plus sign and headroom
   localparam int ERR_BITS = COORD_BITS + 3;
   // Canvas size registers
   localparam int DIM_BITS = 13;
   localparam int COLOR_BITS = 24;
   // Width for comparing a coordinate against a canvas size
   localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   typedef enum logic [0:0] {
      MODE_START = 1'b0,
      MODE_STEP  = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      CSR_CANVAS_WIDTH  = 1'b0,
      CSR_CANVAS_HEIGHT = 1'b1
   } csr_index_type;

   // Per-line stepping state
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [ERR_BITS-1:0]   err;
      logic [COORD_BITS-1:0]        major;
      logic [COORD_BITS-1:0]        minor;
      logic [COORD_BITS-1:0]        remaining;
      logic                         x_major;
      logic                         x_neg;
      logic                         y_neg;
      logic [COLOR_BITS-1:0]        color;
   } line_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        color;
      logic                         in_canvas;
      logic                         last;
   } pixel_type;

   typedef struct packed {
      logic fire;
      logic is_start;
   } step_ctrl_type;

endpackage

FILE: sv/lr_setup.sv
module lr_setup (
   input  logic signed [lr_pkg::COORD_BITS-1:0] start_x,
   input  logic signed [lr_pkg::COORD_BITS-1:0] start_y,
   input  logic signed [lr_pkg::COORD_BITS-1:0] end_x,
   input  logic signed [lr_pkg::COORD_BITS-1:0] end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0]        color,
   output lr_pkg::line_state_type               setup
);
   import lr_pkg::*;

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [COORD_BITS:0]        adx_w;
   logic [COORD_BITS:0]        ady_w;
   logic [COORD_BITS-1:0]      adx;
   logic [COORD_BITS-1:0]      ady;

   // Signed deltas, one bit wider so they cannot overflow
   assign dx = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
   assign dy = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});

   // Magnitudes always fit in COORD_BITS
   assign adx_w = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
   assign ady_w = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
   assign adx   = adx_w[COORD_BITS-1:0];
   assign ady   = ady_w[COORD_BITS-1:0];

   always_comb begin
      setup.x       = start_x;
      setup.y       = start_y;
      // zero delta counts as a negative direction
      setup.x_neg   = dx[COORD_BITS] || (dx == '0);
      setup.y_neg   = dy[COORD_BITS] || (dy == '0);
      setup.x_major = (adx >= ady);
      setup.major   = setup.x_major ? adx : ady;
      setup.minor   = setup.x_major ? ady : adx;
      // e = 2*minor - major
      setup.err     = $signed(ERR_BITS'({setup.minor, 1'b0}) - ERR_BITS'(setup.major));
      setup.remaining = setup.major;
      setup.color   = color;
   end

endmodule

FILE: sv/lr_stepper.sv
module lr_stepper (
   input  logic                          clock,
   input  logic                          reset,
   input  lr_pkg::step_ctrl_type         ctrl,
   input  lr_pkg::line_state_type        setup,
   input  logic [lr_pkg::DIM_BITS-1:0]   canvas_width,
   input  logic [lr_pkg::DIM_BITS-1:0]   canvas_height,
   output logic                          produce,
   output lr_pkg::pixel_type             pixel
);
   import lr_pkg::*;

   line_state_type              line_ff;
   line_state_type              line_in;
   line_state_type              cur;
   logic                        active_ff;
   logic                        active_in;
   logic                        minor_neg;
   logic                        take;
   logic                        err_pos;
   logic signed [ERR_BITS-1:0]  err_next;
   logic signed [COORD_BITS-1:0] x_next;
   logic signed [COORD_BITS-1:0] y_next;

   // A start uses the freshly set up line, a step the held one
   assign cur     = ctrl.is_start ? setup : line_ff;
   assign produce = ctrl.is_start || active_ff;

   // Pixel for the current position
   always_comb begin
      pixel.x         = cur.x;
      pixel.y         = cur.y;
      pixel.color     = cur.color;
      pixel.last      = (cur.remaining == '0);
      pixel.in_canvas = !cur.x[COORD_BITS-1] && !cur.y[COORD_BITS-1] &&
                        (CMP_BITS'(cur.x[COORD_BITS-2:0]) < CMP_BITS'(canvas_width)) &&
                        (CMP_BITS'(cur.y[COORD_BITS-2:0]) < CMP_BITS'(canvas_height));
   end

   // Bresenham decision with the direction-dependent tie rule
   assign minor_neg = cur.x_major ? cur.y_neg : cur.x_neg;
   assign err_pos   = !cur.err[ERR_BITS-1] && (cur.err != '0);
   assign take      = minor_neg ? err_pos : !cur.err[ERR_BITS-1];
   assign err_next  = $signed(cur.err + ERR_BITS'({cur.minor, 1'b0}) -
                              (take ? ERR_BITS'({cur.major, 1'b0}) : ERR_BITS'(0)));
   assign x_next    = cur.x_neg ? (cur.x - 1'b1) : (cur.x + 1'b1);
   assign y_next    = cur.y_neg ? (cur.y - 1'b1) : (cur.y + 1'b1);

   // Next line state
   always_comb begin
      line_in   = line_ff;
      active_in = active_ff;
      if (ctrl.fire && produce) begin
         line_in   = cur;
         active_in = !pixel.last;
         if (!pixel.last) begin
            if (cur.x_major || take) begin
               line_in.x = x_next;
            end
            if (!cur.x_major || take) begin
               line_in.y = y_next;
            end
            line_in.err       = err_next;
            line_in.remaining = cur.remaining - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

endmodule

FILE: sv/line_rasterizer.sv
// A request accepted into the input register passes on to the result register,
// which drives rsp_valid and holds the pixel while rsp_stall is high.
// Throughput: one request per cycle while rsp_stall does not hold a pixel; a
// step request with no active line gives no pixel.
// Reset (synchronous): drops the active line, clears both valid flags and
// sets the canvas to 640 x 480.
module line_rasterizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lr_pkg::mode_type                    req_mode,
   input  logic signed [lr_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [lr_pkg::COORD_BITS-1:0] req_start_y,
   input  logic signed [lr_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [lr_pkg::COORD_BITS-1:0] req_end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0]        req_color,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [lr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                                rsp_inside_res,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  lr_pkg::csr_index_type               csr_index,
   input  logic [lr_pkg::DIM_BITS-1:0]          csr_wr_data
);
   import lr_pkg::*;

   logic                         in_valid_ff;
   logic                         in_valid_in;
   mode_type                     in_mode_ff;
   logic signed [COORD_BITS-1:0] in_start_x_ff;
   logic signed [COORD_BITS-1:0] in_start_y_ff;
   logic signed [COORD_BITS-1:0] in_end_x_ff;
   logic signed [COORD_BITS-1:0] in_end_y_ff;
   logic [COLOR_BITS-1:0]        in_color_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   pixel_type                    out_ff;
   pixel_type                    pixel;
   line_state_type               setup;
   step_ctrl_type                ctrl;
   logic                         produce;
   logic                         out_free;
   logic                         req_take;
   logic [DIM_BITS-1:0]          width_ff;
   logic [DIM_BITS-1:0]          height_ff;

   // Handshake: the input register moves on when the result slot is free
   assign out_free      = !out_valid_ff || !rsp_stall;
   assign ctrl.fire     = in_valid_ff && out_free;
   assign ctrl.is_start = (in_mode_ff == MODE_START);
   assign req_stall     = in_valid_ff && !out_free;
   assign req_take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (ctrl.fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (ctrl.fire) begin
         out_valid_in = produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= req_mode;
         in_start_x_ff <= req_start_x;
         in_start_y_ff <= req_start_y;
         in_end_x_ff   <= req_end_x;
         in_end_y_ff   <= req_end_y;
         in_color_ff   <= req_color;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ctrl.fire && produce) begin
         out_ff <= pixel;
      end
   end

   // Canvas size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CANVAS_WIDTH: begin
               width_ff <= csr_wr_data;
            end
            CSR_CANVAS_HEIGHT: begin
               height_ff <= csr_wr_data;
            end
            default: begin
               width_ff <= width_ff;
            end
         endcase
      end
   end

   lr_setup u_setup (
      .start_x (in_start_x_ff),
      .start_y (in_start_y_ff),
      .end_x   (in_end_x_ff),
      .end_y   (in_end_y_ff),
      .color   (in_color_ff),
      .setup   (setup)
   );

   lr_stepper u_stepper (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .setup         (setup),
      .canvas_width  (width_ff),
      .canvas_height (height_ff),
      .produce       (produce),
      .pixel         (pixel)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_ff.x;
   assign rsp_pixel_y     = out_ff.y;
   assign rsp_pixel_color = out_ff.color;
   assign rsp_inside_res  = out_ff.in_canvas;
   assign rsp_last        = out_ff.last;

endmodule

FILE: sv/lr_checker.sv
`include "line_rasterizer_assert.svh"

module lr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [lr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [lr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   input logic [lr_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   input logic                                rsp_inside_res,
   input logic                                rsp_last
);
   import lr_pkg::*;

   // Nothing comes out of reset pending
   `LR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && !req_stall), "valid after reset")

   // A stalled pixel holds
   `LR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_inside_res) && $stable(rsp_last)), "stalled pixel changed")

   // Requests back up only behind a held pixel
   `LR_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "request stall without held pixel")

   // An inside pixel has no negative coordinate
   `LR_ASSERT(a_inside_sign, clock, reset, (rsp_valid && rsp_inside_res) |-> (!rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1]), "negative pixel flagged inside")

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
